FILE: hw/rtl/cab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

    // register map
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_X_ORIGIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_ORIGIN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PITCH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;

    // field widths
    localparam int ORIGIN_W = 13;
    localparam int FDIM_W   = 13;
    localparam int PITCH_W  = 15;
    localparam int SDIM_W   = 11;
    localparam int COORD_W  = 10;
    localparam int POS_W    = 14;
    localparam int ADDR_W   = 26;
    localparam int CH_W     = 8;
    localparam int PROD_W   = 2 * CH_W;

    // limits
    localparam logic [FDIM_W-1:0] MAX_FRAME_DIM  = 13'd4096;
    localparam logic [SDIM_W-1:0] MAX_SPRITE_DIM = 11'd1024;
    localparam int                PIXEL_BYTES    = 4;

    // reset values
    localparam logic [FDIM_W-1:0]  RST_FRAME_WIDTH   = 13'd640;
    localparam logic [FDIM_W-1:0]  RST_FRAME_HEIGHT  = 13'd480;
    localparam logic [PITCH_W-1:0] RST_FRAME_PITCH   = 15'd2560;
    localparam logic [SDIM_W-1:0]  RST_SPRITE_HEIGHT = 11'd16;

    localparam logic [CH_W-1:0]   CH_MAX    = 8'hFF;
    localparam logic [PROD_W-1:0] ROUND_ADD = 16'd127;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cab_blend_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module cab_blend_lane (
    input  wire logic                    clk,
    input  wire cab_pkg::stage_en_t      en,
    input  wire logic [cab_pkg::CH_W-1:0] alpha,
    input  wire logic [cab_pkg::CH_W-1:0] src,
    input  wire logic [cab_pkg::CH_W-1:0] dest,
    output logic      [cab_pkg::CH_W-1:0] q
);
    import cab_pkg::*;

    logic [PROD_W-1:0] pd_reg, ps_reg;
    logic [PROD_W-1:0] pd_next, ps_next;
    logic [PROD_W-1:0] t_reg, t_next;
    logic [CH_W-1:0]   q_reg, q_next;
    logic [PROD_W-1:0] div_sum;

    // stage 1: the two weighted products
    assign pd_next = PROD_W'(CH_MAX - alpha) * PROD_W'(dest);
    assign ps_next = PROD_W'(alpha) * PROD_W'(src);

    // stage 2: sum plus rounding bias, never above 65152
    assign t_next = pd_reg + ps_reg + ROUND_ADD;

    // stage 3: floor(t / 255) as (t + (t >> 8) + 1) >> 8, exact below 65535
    assign div_sum = t_reg + (t_reg >> CH_W) + PROD_W'(1);
    assign q_next  = div_sum[PROD_W-1:CH_W];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            pd_reg <= pd_next;
            ps_reg <= ps_next;
        end
        if (en.s2)
        begin
            t_reg <= t_next;
        end
        if (en.s3)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/clipped_alpha_blit.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted input word is registered in stages 1, 2 and 3 before its result word is on the output
// throughput: one word per cycle while out_stall is low; three register stages, each advances when free
// stall: a stage holds when the one after it is full and held, bubbles fill up
// reset: valid bits cleared, registers back to 640x480 frame, pitch 2560,
// origin 0,0 and sprite height 16
module clipped_alpha_blit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic [cab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cab_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [cab_pkg::COORD_W-1:0]    src_col,
    input  wire logic [cab_pkg::COORD_W-1:0]    src_row,
    input  wire logic [31:0]                    src_pixel,
    input  wire logic [23:0]                    dest_pixel,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                visible,
    output logic      [cab_pkg::ADDR_W-1:0]     dest_address,
    output logic      [23:0]                    blended_pixel
);
    import cab_pkg::*;

    // configuration registers
    logic [ORIGIN_W-1:0] x_origin_reg, y_origin_reg;
    logic [FDIM_W-1:0]   frame_width_reg, frame_height_reg;
    logic [PITCH_W-1:0]  frame_pitch_reg;
    logic [SDIM_W-1:0]   sprite_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg      <= '0;
            y_origin_reg      <= '0;
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            frame_pitch_reg   <= RST_FRAME_PITCH;
            sprite_height_reg <= RST_SPRITE_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_ORIGIN:      x_origin_reg      <= cfg_data[ORIGIN_W-1:0];
                REG_Y_ORIGIN:      y_origin_reg      <= cfg_data[ORIGIN_W-1:0];
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FDIM_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[FDIM_W-1:0];
                REG_FRAME_PITCH:   frame_pitch_reg   <= cfg_data[PITCH_W-1:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SDIM_W-1:0];
                default:           ; // unknown index, write dropped
            endcase
        end
    end

    // saturated limits
    logic [FDIM_W-1:0] fw_sat, fh_sat;
    logic [SDIM_W-1:0] sh_sat;

    assign fw_sat = (frame_width_reg  > MAX_FRAME_DIM)  ? MAX_FRAME_DIM  : frame_width_reg;
    assign fh_sat = (frame_height_reg > MAX_FRAME_DIM)  ? MAX_FRAME_DIM  : frame_height_reg;
    assign sh_sat = (sprite_height_reg > MAX_SPRITE_DIM) ? MAX_SPRITE_DIM : sprite_height_reg;

    // pipeline control: a stage loads when it is empty or the next one loads
    logic      v1_reg, v2_reg, v3_reg;
    stage_en_t en;

    assign en.s3    = !v3_reg || !out_stall;
    assign en.s2    = !v2_reg || en.s3;
    assign en.s1    = !v1_reg || en.s2;
    assign in_stall = !en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: screen position, two's complement in 14 bits
    // x = x_origin + col, y = y_origin + height - 1 - row (bottom-up flip)
    logic [POS_W-1:0] x1_reg, x1_next;
    logic [POS_W-1:0] y1_reg, y1_next;

    assign x1_next = {x_origin_reg[ORIGIN_W-1], x_origin_reg}
                   + POS_W'(src_col);
    assign y1_next = {y_origin_reg[ORIGIN_W-1], y_origin_reg}
                   + POS_W'(sh_sat) - POS_W'(1) - POS_W'(src_row);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
        end
    end

    // stage 2: clip test and row offset product
    localparam int XC_W = FDIM_W - 1;   // a visible x is below 4096
    localparam int PROD_A_W = XC_W + PITCH_W;

    logic              vis2_reg, vis2_next;
    logic [XC_W-1:0]   x2_reg;
    logic [ADDR_W-1:0] yp2_reg, yp2_next;
    logic [PROD_A_W-1:0] yp_full;

    assign vis2_next = !x1_reg[POS_W-1] && (x1_reg[FDIM_W-1:0] < fw_sat)
                    && !y1_reg[POS_W-1] && (y1_reg[FDIM_W-1:0] < fh_sat);

    // y of a visible pixel fits in 12 bits, address wraps at 26 bits
    assign yp_full  = PROD_A_W'(y1_reg[XC_W-1:0]) * PROD_A_W'(frame_pitch_reg);
    assign yp2_next = yp_full[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            vis2_reg <= vis2_next;
            x2_reg   <= x1_reg[XC_W-1:0];
            yp2_reg  <= yp2_next;
        end
    end

    // stage 3: byte address, zero for clipped pixels
    logic              vis3_reg;
    logic [ADDR_W-1:0] addr3_reg, addr3_next;

    assign addr3_next = vis2_reg
                      ? (ADDR_W'(x2_reg) * ADDR_W'(PIXEL_BYTES) + yp2_reg)
                      : '0;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            vis3_reg  <= vis2_reg;
            addr3_reg <= addr3_next;
        end
    end

    // color lanes run alongside the address path, one per channel
    logic [CH_W-1:0] red_q, green_q, blue_q;

    cab_blend_lane u_lane_red (
        .clk   (clk),
        .en    (en),
        .alpha (src_pixel[31:24]),
        .src   (src_pixel[23:16]),
        .dest  (dest_pixel[23:16]),
        .q     (red_q)
    );

    cab_blend_lane u_lane_green (
        .clk   (clk),
        .en    (en),
        .alpha (src_pixel[31:24]),
        .src   (src_pixel[15:8]),
        .dest  (dest_pixel[15:8]),
        .q     (green_q)
    );

    cab_blend_lane u_lane_blue (
        .clk   (clk),
        .en    (en),
        .alpha (src_pixel[31:24]),
        .src   (src_pixel[7:0]),
        .dest  (dest_pixel[7:0]),
        .q     (blue_q)
    );

    // outputs straight from the last stage
    assign out_valid     = v3_reg;
    assign visible       = vis3_reg;
    assign dest_address  = addr3_reg;
    assign blended_pixel = vis3_reg ? {red_q, green_q, blue_q} : '0;

endmodule

`default_nettype wire
